### src/cf_pkg.sv
// Shared types and constants for the Cholesky factorization unit.
`default_nettype none
package cf_pkg;

    localparam int MAX_SIZE_DEFAULT = 16;
    localparam int DATA_W = 32;
    localparam int ROOT_W = 24;
    localparam int RAD_W = 48;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_FACTOR   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NEG_PIV  = 2'd1;
    localparam logic [1:0] ST_ZERO_PIV = 2'd2;

    localparam logic REG_SIZE = 1'b0;
    localparam logic REG_MODE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_DATA, S_RESP, S_PIV_RD, S_PIV_CHK, S_SQRT, S_PIV_WR,
        S_SC_RD, S_SC_LD, S_DIV, S_SC_WR, S_UP_P, S_UP_Q, S_UP_E, S_UP_MUL,
        S_UP_WR
    } state_t;

endpackage
`default_nettype wire

### src/cf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/cholesky_factorization_unit.sv
// Top level of the Cholesky factorization unit: sequencer, root and divider units.
//
// The block holds a symmetric matrix in Q15.16 and factors it in place.
// Input transactions carry an operation, a row, a column and a value on a
// valid/ready channel. A write stores one element and returns nothing; a read
// returns the element and the first pivot error; a factor transaction computes
// L (lower mode) or U (upper mode) over the active N by N matrix and returns
// data zero with the pivot error status. Results leave on a valid/ready
// channel through an output register.
// A write is stored when it is accepted. A read passes through a data state
// and a response state before its result is presented, and the block then
// returns to idle. A factorization works column by column: a pivot check and
// square root, the scaling of the column and the trailing update; a column
// with a non-positive pivot is skipped. The single read port of the matrix
// memory and the bit-serial root and divider units set its running time.
// The block takes one transaction at a time; s_ready is high only while idle.
// Reset clears the status, sets N to 16 (capped at MAX_SIZE) and selects lower
// mode; the matrix memory is not cleared. When the receiver stalls the result
// waits in the output register and the block holds before presenting another.
`default_nettype none
module cholesky_factorization_unit #(
    parameter int MAX_SIZE = cf_pkg::MAX_SIZE_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [3:0]  s_row,
    input  wire logic [3:0]  s_col,
    input  wire logic signed [31:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_data,
    output logic [1:0]       m_status
);
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(MAX_SIZE + 1);
    localparam int DW = cf_pkg::DATA_W;
    localparam int RW = cf_pkg::ROOT_W;
    localparam int XW = cf_pkg::RAD_W;

    cf_pkg::state_t state_reg, state_next;

    logic [4:0]    size_reg;
    logic          mode_reg;
    logic [1:0]    err_reg;
    logic [IW-1:0] n_reg, k_reg, i_reg, j_reg;
    logic [5:0]    cnt_reg;
    logic          rd_ok_reg;
    logic signed [DW-1:0] resp_reg;
    logic          m_valid_reg;
    logic signed [DW-1:0] m_data_reg;
    logic [1:0]    m_status_reg;

    logic [XW-1:0] rad_reg;
    logic [RW+1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [RW-1:0] s_reg;
    logic [XW-1:0] dq_reg;
    logic [RW-1:0] drem_reg;
    logic          dneg_reg;
    logic signed [DW-1:0] p_reg, q_reg, e_reg;
    logic signed [63:0]   prod_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    logic          accept;
    logic          port_in_range;
    logic [AW-1:0] port_addr;
    logic [IW-1:0] n_eff;
    logic          k_more, i_more, j_more;

    logic [RW+3:0] sq_try, sq_trial;
    logic [RW:0]   dv_try;
    logic signed [DW-1:0] q_sat;
    logic signed [XW:0]   q_signed;
    logic signed [63:0]   prod_adj;
    logic signed [XW:0]   t_val, diff;
    logic signed [DW-1:0] upd_sat;
    logic [DW:0]   a_mag;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(32'(r) * MAX_SIZE + 32'(c));
    endfunction

    assign accept = s_valid && s_ready;
    assign port_in_range = (32'(s_row) < MAX_SIZE) && (32'(s_col) < MAX_SIZE);
    assign port_addr = AW'(32'(s_row) * MAX_SIZE + 32'(s_col));

    always_comb begin
        if (size_reg == 5'd0) begin
            n_eff = IW'(1);
        end else if (32'(size_reg) > MAX_SIZE) begin
            n_eff = IW'(MAX_SIZE);
        end else begin
            n_eff = IW'(size_reg);
        end
    end

    assign k_more = ({1'b0, k_reg} + 1'b1) < {1'b0, n_reg};
    assign i_more = ({1'b0, i_reg} + 1'b1) < {1'b0, n_reg};
    assign j_more = j_reg < i_reg;

    // Square root step: two radicand bits per cycle.
    assign sq_try = {rem_reg, rad_reg[XW-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // Restoring division step: one quotient bit per cycle.
    assign dv_try = {drem_reg, dq_reg[XW-1]};

    assign a_mag = ram_rdata[DW-1] ? (DW+1)'(-$signed({ram_rdata[DW-1], ram_rdata}))
                                   : {1'b0, ram_rdata};

    always_comb begin
        q_signed = dneg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
        if (q_signed > $signed((XW+1)'(32'h7fffffff))) begin
            q_sat = 32'sh7fffffff;
        end else if (q_signed < -$signed((XW+1)'(33'h080000000))) begin
            q_sat = 32'sh80000000;
        end else begin
            q_sat = q_signed[DW-1:0];
        end
    end

    always_comb begin
        prod_adj = prod_reg[63] ? prod_reg + 64'sd65535 : prod_reg;
        t_val = (XW+1)'(prod_adj >>> 16);
        diff = (XW+1)'(e_reg) - t_val;
        if (diff > $signed((XW+1)'(32'h7fffffff))) begin
            upd_sat = 32'sh7fffffff;
        end else if (diff < -$signed((XW+1)'(33'h080000000))) begin
            upd_sat = 32'sh80000000;
        end else begin
            upd_sat = diff[DW-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cf_pkg::S_IDLE: begin
                if (accept && s_operation == cf_pkg::OP_READ) begin
                    state_next = cf_pkg::S_RD_DATA;
                end else if (accept && s_operation == cf_pkg::OP_FACTOR) begin
                    state_next = cf_pkg::S_PIV_RD;
                end
            end
            cf_pkg::S_RD_DATA: state_next = cf_pkg::S_RESP;
            cf_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = cf_pkg::S_IDLE;
                end
            end
            cf_pkg::S_PIV_RD:  state_next = cf_pkg::S_PIV_CHK;
            cf_pkg::S_PIV_CHK: begin
                if ($signed(ram_rdata) > 0) begin
                    state_next = cf_pkg::S_SQRT;
                end else if (k_more) begin
                    state_next = cf_pkg::S_PIV_RD;
                end else begin
                    state_next = cf_pkg::S_RESP;
                end
            end
            cf_pkg::S_SQRT: begin
                if (cnt_reg == 6'(RW - 1)) begin
                    state_next = cf_pkg::S_PIV_WR;
                end
            end
            cf_pkg::S_PIV_WR: state_next = k_more ? cf_pkg::S_SC_RD : cf_pkg::S_RESP;
            cf_pkg::S_SC_RD:  state_next = cf_pkg::S_SC_LD;
            cf_pkg::S_SC_LD:  state_next = cf_pkg::S_DIV;
            cf_pkg::S_DIV: begin
                if (cnt_reg == 6'(XW - 1)) begin
                    state_next = cf_pkg::S_SC_WR;
                end
            end
            cf_pkg::S_SC_WR:  state_next = i_more ? cf_pkg::S_SC_RD : cf_pkg::S_UP_P;
            cf_pkg::S_UP_P:   state_next = cf_pkg::S_UP_Q;
            cf_pkg::S_UP_Q:   state_next = cf_pkg::S_UP_E;
            cf_pkg::S_UP_E:   state_next = cf_pkg::S_UP_MUL;
            cf_pkg::S_UP_MUL: state_next = cf_pkg::S_UP_WR;
            cf_pkg::S_UP_WR: begin
                if (j_more || i_more) begin
                    state_next = cf_pkg::S_UP_P;
                end else if (k_more) begin
                    state_next = cf_pkg::S_PIV_RD;
                end else begin
                    state_next = cf_pkg::S_RESP;
                end
            end
            default: state_next = cf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == cf_pkg::S_IDLE);
        ram_we = 1'b0;
        ram_waddr = port_addr;
        ram_wdata = s_value;
        ram_raddr = port_addr;
        case (state_reg)
            cf_pkg::S_IDLE: begin
                ram_we = accept && s_operation == cf_pkg::OP_WRITE && port_in_range;
            end
            cf_pkg::S_PIV_RD: ram_raddr = cell_addr(k_reg, k_reg);
            cf_pkg::S_PIV_WR: begin
                ram_we = 1'b1;
                ram_waddr = cell_addr(k_reg, k_reg);
                ram_wdata = DW'(root_reg);
            end
            cf_pkg::S_SC_RD: begin
                ram_raddr = mode_reg ? cell_addr(i_reg, k_reg) : cell_addr(k_reg, i_reg);
            end
            cf_pkg::S_SC_WR: begin
                ram_we = 1'b1;
                ram_waddr = mode_reg ? cell_addr(i_reg, k_reg) : cell_addr(k_reg, i_reg);
                ram_wdata = q_sat;
            end
            cf_pkg::S_UP_P: begin
                ram_raddr = mode_reg ? cell_addr(i_reg, k_reg) : cell_addr(k_reg, j_reg);
            end
            cf_pkg::S_UP_Q: begin
                ram_raddr = mode_reg ? cell_addr(j_reg, k_reg) : cell_addr(k_reg, i_reg);
            end
            cf_pkg::S_UP_E: begin
                ram_raddr = mode_reg ? cell_addr(i_reg, j_reg) : cell_addr(j_reg, i_reg);
            end
            cf_pkg::S_UP_WR: begin
                ram_we = 1'b1;
                ram_waddr = mode_reg ? cell_addr(i_reg, j_reg) : cell_addr(j_reg, i_reg);
                ram_wdata = upd_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cf_pkg::S_IDLE;
            size_reg <= 5'd16;
            mode_reg <= 1'b1;
            err_reg <= cf_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && cfg_index == cf_pkg::REG_SIZE) begin
                size_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == cf_pkg::REG_MODE) begin
                mode_reg <= cfg_wdata[0];
            end
            if (state_reg == cf_pkg::S_IDLE && accept && s_operation == cf_pkg::OP_FACTOR) begin
                err_reg <= cf_pkg::ST_OK;
            end
            if (state_reg == cf_pkg::S_PIV_CHK && $signed(ram_rdata) <= 0
                    && err_reg == cf_pkg::ST_OK) begin
                err_reg <= ram_rdata[DW-1] ? cf_pkg::ST_NEG_PIV : cf_pkg::ST_ZERO_PIV;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == cf_pkg::S_RESP && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            cf_pkg::S_IDLE: begin
                rd_ok_reg <= port_in_range;
                n_reg <= n_eff;
                k_reg <= '0;
                resp_reg <= '0;
            end
            cf_pkg::S_RD_DATA: resp_reg <= rd_ok_reg ? $signed(ram_rdata) : '0;
            cf_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_reg <= resp_reg;
                    m_status_reg <= err_reg;
                end
            end
            cf_pkg::S_PIV_CHK: begin
                rad_reg <= {ram_rdata, 16'b0};
                rem_reg <= '0;
                root_reg <= '0;
                cnt_reg <= '0;
                resp_reg <= '0;
                if ($signed(ram_rdata) <= 0) begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            cf_pkg::S_SQRT: begin
                rad_reg <= {rad_reg[XW-3:0], 2'b00};
                cnt_reg <= cnt_reg + 1'b1;
                if (sq_try >= sq_trial) begin
                    rem_reg <= (RW+2)'(sq_try - sq_trial);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_reg <= (RW+2)'(sq_try);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            cf_pkg::S_PIV_WR: begin
                s_reg <= root_reg;
                i_reg <= k_reg + 1'b1;
                if (!k_more) begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            cf_pkg::S_SC_LD: begin
                dq_reg <= {a_mag[DW-1:0], 16'b0};
                drem_reg <= '0;
                dneg_reg <= ram_rdata[DW-1];
                cnt_reg <= '0;
            end
            cf_pkg::S_DIV: begin
                dq_reg <= {dq_reg[XW-2:0], (dv_try >= {1'b0, s_reg})};
                drem_reg <= (dv_try >= {1'b0, s_reg}) ? RW'(dv_try - {1'b0, s_reg})
                                                        : RW'(dv_try);
                cnt_reg <= cnt_reg + 1'b1;
            end
            cf_pkg::S_SC_WR: begin
                if (i_more) begin
                    i_reg <= i_reg + 1'b1;
                end else begin
                    i_reg <= k_reg + 1'b1;
                    j_reg <= k_reg + 1'b1;
                end
            end
            cf_pkg::S_UP_Q: p_reg <= $signed(ram_rdata);
            cf_pkg::S_UP_E: q_reg <= $signed(ram_rdata);
            cf_pkg::S_UP_MUL: begin
                e_reg <= $signed(ram_rdata);
                prod_reg <= p_reg * q_reg;
            end
            cf_pkg::S_UP_WR: begin
                if (j_more) begin
                    j_reg <= j_reg + 1'b1;
                end else if (i_more) begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= k_reg + 1'b1;
                end else begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    cf_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
    assign m_status = m_status_reg;

endmodule
`default_nettype wire

### src/cf_checker.sv
// Port-level checks for the Cholesky factorization unit and their binding.
`default_nettype none
module cf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_operation,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_data,
    input wire logic [1:0]  m_status
);
    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data) && $stable(m_status))
        else $error("result changed while stalled");

    // An accepted read or factorization makes the block busy.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_operation == cf_pkg::OP_READ || s_operation == cf_pkg::OP_FACTOR)
        |=> !s_ready)
        else $error("input accepted while a transaction is in progress");

    // A new result is only produced while the block is busy.
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a transaction in progress");

    // The status is never an undefined code.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("undefined status code");
endmodule

bind cholesky_factorization_unit cf_checker u_cf_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_operation(s_operation),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_data     (m_data),
    .m_status   (m_status)
);
`default_nettype wire
